FILE: design/b64c_pkg.sv
// Shared types, register indexes and alphabet functions for the Base64 codec stream.
// No dependencies; every design file imports this package.
package b64c_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int JOB_BYTES   = 5;
  localparam int JOB_CNT_W   = 3;
  localparam int WRAP_RESET  = 76;

  localparam logic REG_DECODE_MODE  = 1'b0;
  localparam logic REG_WRAP_COLUMNS = 1'b1;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // One accepted item's worth of output bytes; data[0] goes out first.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] data;
    logic [JOB_CNT_W-1:0]      count;
  } job_t;

  // Sextet to alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] r;
    if (s < 6'd26) begin
      r = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      r = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      r = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // Character to sextet; bit 6 set means outside the alphabet.
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r = 7'd62;
    end else if (c == 8'h2F) begin
      r = 7'd63;
    end else begin
      r = 7'd64;
    end
    return r;
  endfunction

endpackage

FILE: design/b64c_front.sv
// Front end: accepts items, holds group and column state, builds at most one job per item.
// Depends on b64c_pkg.
module b64c_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  b64c_pkg::in_item_t item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              job_valid,
  output b64c_pkg::job_t    job
);
  import b64c_pkg::*;

  logic        decode_mode_r;
  logic [7:0]  wrap_r;
  logic [23:0] group_bits_r, group_bits_nxt;
  logic [1:0]  group_count_r, group_count_nxt;
  logic [7:0]  column_r, column_nxt;

  logic [23:0] merged;
  logic [6:0]  sextet;
  logic [8:0]  col_sum;

  always_comb begin
    group_bits_nxt  = group_bits_r;
    group_count_nxt = group_count_r;
    column_nxt      = column_r;
    job             = '0;
    merged          = group_bits_r;
    sextet          = dec_char(item.data_byte);
    col_sum         = {1'b0, column_r} + 9'd4;

    if (item.end_marker) begin
      if (!decode_mode_r) begin
        if (group_count_r == 2'd1) begin
          job.data[0] = enc_char(group_bits_r[23:18]);
          job.data[1] = enc_char(group_bits_r[17:12]);
          job.data[2] = PAD_CHAR;
          job.data[3] = PAD_CHAR;
          job.data[4] = NEWLINE_CHAR;
          job.count   = 3'd5;
        end else if (group_count_r == 2'd2) begin
          job.data[0] = enc_char(group_bits_r[23:18]);
          job.data[1] = enc_char(group_bits_r[17:12]);
          job.data[2] = enc_char(group_bits_r[11:6]);
          job.data[3] = PAD_CHAR;
          job.data[4] = NEWLINE_CHAR;
          job.count   = 3'd5;
        end else if (column_r != 8'd0) begin
          job.data[0] = NEWLINE_CHAR;
          job.count   = 3'd1;
        end
      end else begin
        job.data[0] = group_bits_r[23:16];
        job.data[1] = group_bits_r[15:8];
        if (group_count_r == 2'd2) begin
          job.count = 3'd1;
        end else if (group_count_r == 2'd3) begin
          job.count = 3'd2;
        end
      end
      group_bits_nxt  = '0;
      group_count_nxt = '0;
      column_nxt      = '0;
    end else if (!decode_mode_r) begin
      case (group_count_r)
        2'd0:    merged = group_bits_r | {item.data_byte, 16'h0};
        2'd1:    merged = group_bits_r | {8'h0, item.data_byte, 8'h0};
        default: merged = group_bits_r | {16'h0, item.data_byte};
      endcase
      if (group_count_r[1]) begin
        // Third byte completes the group: four characters, maybe a newline.
        job.data[0] = enc_char(merged[23:18]);
        job.data[1] = enc_char(merged[17:12]);
        job.data[2] = enc_char(merged[11:6]);
        job.data[3] = enc_char(merged[5:0]);
        if (col_sum >= {1'b0, wrap_r}) begin
          job.data[4] = NEWLINE_CHAR;
          job.count   = 3'd5;
          column_nxt  = '0;
        end else begin
          job.count   = 3'd4;
          column_nxt  = col_sum[7:0];
        end
        group_bits_nxt  = '0;
        group_count_nxt = '0;
      end else begin
        group_bits_nxt  = merged;
        group_count_nxt = group_count_r + 2'd1;
      end
    end else if (!sextet[6]) begin
      case (group_count_r)
        2'd0:    merged = group_bits_r | {sextet[5:0], 18'h0};
        2'd1:    merged = group_bits_r | {6'h0, sextet[5:0], 12'h0};
        2'd2:    merged = group_bits_r | {12'h0, sextet[5:0], 6'h0};
        default: merged = group_bits_r | {18'h0, sextet[5:0]};
      endcase
      group_count_nxt = group_count_r + 2'd1;
      if (group_count_r == 2'd3) begin
        job.data[0]    = merged[23:16];
        job.data[1]    = merged[15:8];
        job.data[2]    = merged[7:0];
        job.count      = 3'd3;
        group_bits_nxt = '0;
      end else begin
        group_bits_nxt = merged;
      end
    end
  end

  assign job_valid = accept && (job.count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      wrap_r        <= 8'(WRAP_RESET);
      group_bits_r  <= '0;
      group_count_r <= '0;
      column_r      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DECODE_MODE) begin
        decode_mode_r <= cfg_data[0];
        group_bits_r  <= '0;
        group_count_r <= '0;
        column_r      <= '0;
      end else begin
        wrap_r <= cfg_data;
      end
    end else if (accept) begin
      group_bits_r  <= group_bits_nxt;
      group_count_r <= group_count_nxt;
      column_r      <= column_nxt;
    end
  end

endmodule

FILE: design/b64c_queue.sv
// Small register queue of jobs between the front and back ends.
// Depends on b64c_pkg.
module b64c_queue #(
  parameter int DEPTH = b64c_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64c_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output b64c_pkg::job_t head
);
  import b64c_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/b64c_back.sv
// Back end: walks the head job one byte per cycle into the result register.
// Stalls while the result register holds an unpopped byte. Depends on b64c_pkg.
module b64c_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  b64c_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output b64c_pkg::out_item_t out_data
);
  import b64c_pkg::*;

  logic [JOB_CNT_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r;
  out_item_t            out_r, out_nxt;
  logic                 load, last;

  assign load = !q_empty && (!out_valid_r || out_pop);
  assign last = (idx_r == q_head.count - 1'b1);
  assign q_pop = load && last;

  always_comb begin
    out_nxt.out_byte    = q_head.data[idx_r];
    out_nxt.last_of_run = last;
    idx_nxt             = last ? '0 : idx_r + 1'b1;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: design/base64_codec_stream.sv
// Base64 codec stream top level: front end, job queue and back end; depends on b64c_pkg.
// Latency: an accepted item's job is registered in the job queue; its first result byte
//   is loaded into the back end's output register once the bytes ahead of it have left.
// Throughput: one item accepted per cycle while the job queue has room; results leave
//   at one byte per cycle from the back end's output register while out_pop is held,
//   and full encode groups give four or five characters per three input bytes.
// Reset (rst_n low, synchronous): encode mode, wrap at 76 columns, all held state cleared.
module base64_codec_stream #(
  parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                in_push,
  output logic                in_full,
  input  b64c_pkg::in_item_t  in_data,
  // result items
  output logic                out_empty,
  input  logic                out_pop,
  output b64c_pkg::out_item_t out_data,
  // configuration writes
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);
  import b64c_pkg::*;

  logic accept;
  logic job_valid;
  job_t job;
  logic q_full, q_empty, q_pop;
  job_t q_head;

  // Hold off new items whenever the queue cannot take a job, even one that
  // would produce nothing; this keeps the accept rule a single flop compare.
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Front: classify the beat, update group and column state, build the job.
  b64c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job       (job)
  );

  // Queue: decouple the front's bursty jobs from the byte-wide back end.
  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back: drain each job one result beat at a time, flag the last one.
  b64c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

FILE: dv/tb_base64_codec_stream.sv
// Testbench for base64_codec_stream: directed table, then random encode/decode streams.
// Checks each result beat against table text or an in-bench Base64 predictor; depends on b64c_pkg.
module tb_base64_codec_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import b64c_pkg::*;

  localparam int IDLE_LIMIT    = 4000;  // cycles with no beat on any port
  localparam int SETTLE_CYCLES = 8;     // allow for a silent item to clear the pipeline
  localparam int SESSIONS      = 20;
  localparam int LONG_STREAM   = 195;   // enough groups to bring the column to 252 and wrap

  // Standard alphabet, character 0 in the top byte.
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table. ntyped < 0 means: take the expectation from the
  // predictor; otherwise txt holds ntyped result bytes, the first one highest.
  typedef struct {
    row_kind_e   kind;
    logic        cfg_idx;
    logic [7:0]  value;
    logic        end_mark;
    int          ntyped;
    logic [39:0] txt;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  // Predictor state and configuration copy.
  logic        mode_q;
  logic [7:0]  wrap_q;
  logic [23:0] grp_bits;
  logic [1:0]  grp_cnt;
  logic [7:0]  col_cnt;
  logic [7:0]  pred_buf[5];
  int          pred_n;

  out_item_t pending_out[$];   // result beats still owed by the block
  stim_row_t rows[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        send_gap_pct = 0;
  int        sink_stall_pct = 0;

  base64_codec_stream u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] alpha_char(int s);
    return B64_ALPHABET[8*(63-s) +: 8];
  endfunction

  // Search the alphabet; 64 flags a character to skip.
  function automatic int sextet_of(logic [7:0] c);
    for (int k = 0; k < 64; k++) begin
      if (alpha_char(k) == c) return k;
    end
    return 64;
  endfunction

  function automatic void emit(logic [7:0] b);
    pred_buf[pred_n] = b;
    pred_n++;
  endfunction

  function automatic void clear_codec();
    grp_bits = '0;
    grp_cnt  = '0;
    col_cnt  = '0;
  endfunction

  function automatic void codec_step(in_item_t it);
    int i;
    int v;
    pred_n = 0;
    if (!mode_q) begin
      if (it.end_marker) begin
        // Flush a partial group with padding and a newline, or close an open line.
        if (grp_cnt == 2'd1 || grp_cnt == 2'd2) begin
          for (i = 0; i <= int'(grp_cnt); i++) emit(alpha_char(int'(grp_bits >> (18 - 6*i)) & 63));
          for (; i < 4; i++) emit(PAD_CHAR);
          emit(NEWLINE_CHAR);
        end else if (col_cnt != 8'd0) begin
          emit(NEWLINE_CHAR);
        end
        clear_codec();
      end else begin
        if (grp_cnt > 2'd2) grp_cnt = 2'd2;
        grp_bits = grp_bits | (24'(it.data_byte) << (16 - 8*int'(grp_cnt)));
        grp_cnt++;
        if (grp_cnt == 2'd3) begin
          for (i = 0; i < 4; i++) emit(alpha_char(int'(grp_bits >> (18 - 6*i)) & 63));
          grp_bits = '0;
          grp_cnt  = '0;
          // Compare at full width so a column of 252 and up still wraps cleanly.
          if (int'(col_cnt) + 4 >= int'(wrap_q)) begin
            emit(NEWLINE_CHAR);
            col_cnt = '0;
          end else begin
            col_cnt = col_cnt + 8'd4;
          end
        end
      end
    end else begin
      if (it.end_marker) begin
        // Two or three held sextets leave one or two whole bytes; one leaves none.
        if (grp_cnt >= 2'd2) begin
          for (i = 0; i + 1 < int'(grp_cnt); i++) emit(8'(grp_bits >> (16 - 8*i)));
        end
        clear_codec();
      end else begin
        v = sextet_of(it.data_byte);
        if (v < 64) begin
          grp_bits = grp_bits | (24'(v) << (18 - 6*int'(grp_cnt)));
          grp_cnt++;
          if (grp_cnt == 2'd0) begin
            for (i = 0; i < 3; i++) emit(8'(grp_bits >> (16 - 8*i)));
            grp_bits = '0;
          end
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // Hold push high until the beat is taken; leave it high so back-to-back beats stream.
  task automatic push_item(in_item_t it, int ntyped, logic [39:0] txt);
    int n;
    logic [7:0] b;
    while ($urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full !== 1'b0);
    codec_step(it);
    n = (ntyped < 0) ? pred_n : ntyped;
    for (int k = 0; k < n; k++) begin
      b = (ntyped < 0) ? pred_buf[k] : txt[8*(n-1-k) +: 8];
      pending_out.push_back(out_item_t'{out_byte: b, last_of_run: (k == n - 1)});
    end
  endtask

  // Drop push, drain every owed beat, then let a silent item clear the pipeline.
  task automatic wait_idle();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_DECODE_MODE) begin
      mode_q = val[0];
      clear_codec();   // any mode write drops held data
    end else begin
      wrap_q = val;
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic void add_item(logic [7:0] b, logic e, int ntyped, logic [39:0] txt);
    rows.push_back('{kind: ROW_ITEM, cfg_idx: 1'b0, value: b, end_mark: e,
                     ntyped: ntyped, txt: txt});
  endfunction

  function automatic void add_cfg(logic idx, logic [7:0] val);
    rows.push_back('{kind: ROW_CFG, cfg_idx: idx, value: val, end_mark: 1'b0,
                     ntyped: -1, txt: '0});
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(4))
      0: return PAD_CHAR;
      1: return NEWLINE_CHAR;
      2: return 8'h20;
      3: return 8'h0D;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------- result side

  // Pop at random, check each result beat against the oldest owed one.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (pending_out.size() == 0) begin
        report_mismatch("unexpected result", out_data.out_byte, 8'h00);
      end else begin
        want = pending_out.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 8'(out_data.last_of_run), 8'(want.last_of_run));
      end
    end
    out_pop <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Count cycles with no beat anywhere; a stuck block trips the watchdog.
  always @(posedge clk) begin
    if ((in_push && in_full === 1'b0) || (out_pop && out_empty === 1'b0) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t watchdog: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("** base64_codec_stream: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int len;
    logic mode_v;
    logic [7:0] wrap_v;
    logic do_mode;
    logic do_wrap;
    in_item_t it;
    logic       mode_pick[8] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [7:0] wrap_pick[8] = '{8'd4, 8'd252, 8'd255, 8'd0, 8'd76, 8'd3, 8'd255, 8'd1};

    mode_q = 1'b0;
    wrap_q = 8'(WRAP_RESET);
    clear_codec();

    // Encode at reset: empty flush, full groups, a closing newline, both padded flushes.
    add_item(8'hFF, 1'b1, 0, 0);
    add_item(8'h00, 1'b0, 0, 0);
    add_item(8'h00, 1'b0, 0, 0);
    add_item(8'h00, 1'b0, 4, "AAAA");
    add_item(8'hFF, 1'b0, 0, 0);
    add_item(8'hFF, 1'b0, 0, 0);
    add_item(8'hFF, 1'b0, 4, "////");
    add_item(8'h00, 1'b1, 1, "\n");
    add_item(8'hFF, 1'b0, 0, 0);
    add_item(8'hFF, 1'b1, 5, "/w==\n");
    add_item(8'hFF, 1'b0, 0, 0);
    add_item(8'hFF, 1'b0, 0, 0);
    add_item(8'h5A, 1'b1, 5, "//8=\n");
    // Wrap below four: newline after every group.
    add_cfg(REG_WRAP_COLUMNS, 8'd3);
    add_item(8'hFB, 1'b0, 0, 0);
    add_item(8'hEF, 1'b0, 0, 0);
    add_item(8'hBE, 1'b0, 5, "++++\n");
    add_item(8'h00, 1'b1, -1, 0);
    // Decode: skipped characters, a full group, and a lone sextet dropped at the end.
    add_cfg(REG_DECODE_MODE, 8'hFF);
    add_item(PAD_CHAR, 1'b0, 0, 0);
    add_item(8'hFF, 1'b0, 0, 0);
    add_item(8'h20, 1'b0, 0, 0);
    add_item("/", 1'b0, 0, 0);
    add_item("/", 1'b0, 0, 0);
    add_item("/", 1'b0, 0, 0);
    add_item("/", 1'b0, 3, 24'hFFFFFF);
    add_item("A", 1'b0, 0, 0);
    add_item(8'h00, 1'b1, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table with both sides streaming.
    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(rows[r].cfg_idx, rows[r].value);
      end else begin
        it.data_byte  = rows[r].value;
        it.end_marker = rows[r].end_mark;
        push_item(it, rows[r].ntyped, rows[r].txt);
      end
    end

    // Random sessions: one setting each, idle profile rotating through four phases.
    for (int s = 0; s < SESSIONS; s++) begin
      wait_idle();
      case (s % 4)
        0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_gap_pct = 86; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 86; end
        default: begin send_gap_pct = 23; sink_stall_pct = 23; end
      endcase
      if (s < 8) begin
        do_mode = 1'b1;
        do_wrap = 1'b1;
        mode_v  = mode_pick[s];
        wrap_v  = wrap_pick[s];
      end else begin
        do_mode = ($urandom_range(9) < 7);
        do_wrap = !do_mode || ($urandom_range(1) == 1);
        mode_v  = 1'($urandom_range(1));
        wrap_v  = 8'($urandom_range(255));
      end
      // Upper data bits must be ignored on a mode write.
      if (do_mode) write_reg(REG_DECODE_MODE, {7'($urandom_range(127)), mode_v});
      if (do_wrap) write_reg(REG_WRAP_COLUMNS, wrap_v);

      len = (s == 2) ? LONG_STREAM : $urandom_range(4);
      for (int k = 0; k < len; k++) begin
        it.end_marker = 1'b0;
        if (!mode_q || $urandom_range(99) < 15) begin
          it.data_byte = mode_q ? noise_char() : 8'($urandom_range(255));
        end else begin
          it.data_byte = alpha_char($urandom_range(63));
        end
        // Now and then drop a stray end marker mid-stream; keep the long stream whole
        // so its column really climbs to 252 and wraps.
        if (s != 2 && $urandom_range(99) < 4) it.end_marker = 1'b1;
        push_item(it, -1, 0);
      end
      // Most streams close with an end marker; the rest leave state for the next write.
      if ($urandom_range(99) < 85) begin
        it.data_byte  = 8'($urandom_range(255));
        it.end_marker = 1'b1;
        push_item(it, -1, 0);
      end
    end

    // Drain, then hold a little longer to catch stray beats.
    in_push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** base64_codec_stream: PASSED **");
    end else begin
      $display("** base64_codec_stream: FAILED **");
    end
    $finish;
  end

endmodule
